// File: design/set_assoc_lru_cache_model_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model
// Wraps concurrent assertions so that synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_UNIT_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every edge outside reset.
`define SACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger, outside reset.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SACL_ASSERT(lbl, prop, msg)
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: design/sacl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Package for the set-associative LRU cache model
// Payload types, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int AddrW    = 32;
  localparam int TagW     = 32;
  localparam int CountW   = 32;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 5;

  // Trace operation codes.
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } op_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BLOCK_BITS = 2'd2;

  // Configuration reset values.
  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

  typedef struct packed {
    op_e              operation;
    logic [AddrW-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              was_hit;
    logic              was_miss;
    logic              was_evicted;
    logic              last;
    logic [CountW-1:0] hit_total;
    logic [CountW-1:0] miss_total;
    logic [CountW-1:0] eviction_total;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

// File: design/sacl_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One transaction moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface sacl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/set_assoc_lru_cache_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative LRU cache model
// Counts hits, misses and evictions of a trace against a modeled cache.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries trace accesses (operation, address). out_o returns one
//   result per cache access; a modify returns two, the second flagged last
//   and always a hit. An instruction fetch returns nothing.
//   cfg_i writes set_bits (0), ways (1) and block_bits (2); other indexes are
//   ignored. Write configuration only while the block is idle.
// Sequence:
//   A load or store reads the set row from the line memory on accept, then
//   updates it and writes it back. A modify has an extra step for its second
//   result. An instruction fetch is accepted with no further step.
//   The first result is registered together with the row write-back.
// Reset and stalls:
//   Reset clears counters and a per-set valid flag, so no clearing pass
//   runs, and loads the configuration reset values. A result waits in the
//   output register while the receiver stalls; a new access is still taken,
//   and the block holds its update until the register is free.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_unit
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sacl_stream_if.sink   in_i,
  sacl_stream_if.source out_o,
  sacl_stream_if.sink   cfg_i
);

  localparam int NumSets = 1 << MAX_SET_BITS;
  localparam int SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RankW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WayIdxW = RankW;
  localparam int WayCntW = $clog2(MAX_WAYS + 1);
  localparam logic [RankW-1:0] RankMax = RankW'(MAX_WAYS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_SECOND = 3'b100
  } state_e;

  // One memory row holds every way of a set.
  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][TagW-1:0]  tag;
    logic [MAX_WAYS-1:0][RankW-1:0] rank;
  } row_t;

  state_e state_q, state_d;

  logic [3:0] set_bits_q;
  logic [3:0] ways_q;
  logic [4:0] block_bits_q;

  logic [CountW-1:0] hit_q, miss_q, evict_q;
  logic [CountW-1:0] hit_d, miss_d, evict_d;

  logic [SetW-1:0] set_q;
  logic [TagW-1:0] tag_q;
  logic            mod_q;

  row_t            mem_q [NumSets];
  row_t            rd_row_q;
  logic            rd_row_valid_q;
  logic [NumSets-1:0] row_valid_q;

  out_item_t out_q;
  logic      out_valid_q;

  logic in_accept;
  logic load_out;
  logic mem_we;

  // --------------------------------------------------------------------------
  // Handshakes.
  // --------------------------------------------------------------------------
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign load_out = ((state_q == S_UPDATE) || (state_q == S_SECOND)) &&
                    (!out_valid_q || out_o.ready);
  assign mem_we   = load_out && (state_q == S_UPDATE);

  // --------------------------------------------------------------------------
  // Address split into set index and tag.
  // --------------------------------------------------------------------------
  logic [3:0]      sb_eff;
  logic [5:0]      split_sum;
  logic [SetW-1:0] set_mask;
  logic [SetW-1:0] set_d;
  logic [TagW-1:0] tag_d;
  logic [AddrW-1:0] addr_shift;

  always_comb begin
    sb_eff = (int'(set_bits_q) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_q;
    for (int i = 0; i < SetW; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
    addr_shift = in_i.payload.address >> block_bits_q;
    set_d      = addr_shift[SetW-1:0] & set_mask;
    split_sum  = 6'(sb_eff) + 6'(block_bits_q);
    tag_d      = (split_sum < 6'd32) ? (in_i.payload.address >> split_sum) : '0;
  end

  // --------------------------------------------------------------------------
  // Line memory: row read on accept, row written back on update.
  // --------------------------------------------------------------------------
  row_t new_row;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_row_q <= mem_q[set_d];
      set_q    <= set_d;
      tag_q    <= tag_d;
      mod_q    <= (in_i.payload.operation == OP_MODIFY);
    end
    if (mem_we) begin
      mem_q[set_q] <= new_row;
    end
  end

  // Per-set flag: a set never written reads as all ways invalid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q    <= '0;
      rd_row_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        rd_row_valid_q <= row_valid_q[set_d];
      end
      if (mem_we) begin
        row_valid_q[set_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Lookup, replacement choice and recency update of the read row.
  // --------------------------------------------------------------------------
  logic [WayCntW-1:0]             nw;
  logic [MAX_WAYS-1:0]            way_act;
  logic [MAX_WAYS-1:0]            vld;
  logic [MAX_WAYS-1:0][RankW-1:0] rank_eff;
  logic                           hit_found, inv_found, fresh;
  logic [WayIdxW-1:0]             hit_way, inv_way, victim, sel;
  logic [RankW-1:0]               best, mine;

  always_comb begin
    if (ways_q == 4'd0) begin
      nw = WayCntW'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      nw = WayCntW'(MAX_WAYS);
    end else begin
      nw = WayCntW'(ways_q);
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      way_act[w]  = (w < int'(nw));
      vld[w]      = rd_row_valid_q && rd_row_q.valid[w];
      rank_eff[w] = rd_row_valid_q ? rd_row_q.rank[w] : '0;
    end

    // First matching valid way.
    hit_found = 1'b0;
    hit_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!hit_found && way_act[w] && vld[w] && (rd_row_q.tag[w] == tag_q)) begin
        hit_found = 1'b1;
        hit_way   = WayIdxW'(w);
      end
    end

    // First invalid way.
    inv_found = 1'b0;
    inv_way   = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!inv_found && way_act[w] && !vld[w]) begin
        inv_found = 1'b1;
        inv_way   = WayIdxW'(w);
      end
    end

    // Oldest way; the lowest-numbered one wins a tie.
    best   = rank_eff[0];
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (way_act[w] && (rank_eff[w] > best)) begin
        best   = rank_eff[w];
        victim = WayIdxW'(w);
      end
    end

    if (hit_found) begin
      sel   = hit_way;
      mine  = rank_eff[hit_way];
      fresh = 1'b0;
    end else if (inv_found) begin
      sel   = inv_way;
      mine  = '0;
      fresh = 1'b1;
    end else begin
      sel   = victim;
      mine  = best;
      fresh = 1'b0;
    end

    // The selected way becomes youngest; younger valid ways age by one.
    for (int v = 0; v < MAX_WAYS; v++) begin
      if (WayIdxW'(v) == sel) begin
        new_row.valid[v] = 1'b1;
        new_row.tag[v]   = tag_q;
        new_row.rank[v]  = '0;
      end else begin
        new_row.valid[v] = vld[v];
        new_row.tag[v]   = rd_row_q.tag[v];
        if (way_act[v] && vld[v] && (fresh || (rank_eff[v] < mine)) &&
            (rank_eff[v] < RankMax)) begin
          new_row.rank[v] = rank_eff[v] + RankW'(1);
        end else begin
          new_row.rank[v] = rank_eff[v];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Running totals.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_d   = hit_q;
    miss_d  = miss_q;
    evict_d = evict_q;
    if (load_out) begin
      if (state_q == S_SECOND || hit_found) begin
        hit_d = hit_q + CountW'(1);
      end else begin
        miss_d = miss_q + CountW'(1);
        if (!inv_found) begin
          evict_d = evict_q + CountW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control sequence.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && (in_i.payload.operation != OP_IFETCH)) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (load_out) begin
          state_d = mod_q ? S_SECOND : S_IDLE;
        end
      end
      S_SECOND: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      set_bits_q   <= SET_BITS_RST;
      ways_q       <= WAYS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      hit_q        <= '0;
      miss_q       <= '0;
      evict_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hit_q   <= hit_d;
      miss_q  <= miss_d;
      evict_q <= evict_d;

      // Configuration transaction.
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.payload.index)
          CFG_SET_BITS:   set_bits_q   <= cfg_i.payload.data[3:0];
          CFG_WAYS:       ways_q       <= cfg_i.payload.data[3:0];
          CFG_BLOCK_BITS: block_bits_q <= cfg_i.payload.data;
          default: ;
        endcase
      end

      // Output register occupancy.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.hit_total      <= hit_d;
      out_q.miss_total     <= miss_d;
      out_q.eviction_total <= evict_d;
      if (state_q == S_SECOND) begin
        out_q.was_hit     <= 1'b1;
        out_q.was_miss    <= 1'b0;
        out_q.was_evicted <= 1'b0;
        out_q.last        <= 1'b1;
      end else begin
        out_q.was_hit     <= hit_found;
        out_q.was_miss    <= !hit_found;
        out_q.was_evicted <= !hit_found && !inv_found;
        out_q.last        <= !mod_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
`include "set_assoc_lru_cache_model_unit_assert.svh"

  `SACL_ASSERT(a_hit_xor_miss, out_valid_q |-> (out_q.was_hit != out_q.was_miss), "hit and miss flags disagree")
  `SACL_ASSERT(a_evict_is_miss, (out_valid_q && out_q.was_evicted) |-> out_q.was_miss, "eviction without a miss")
  `SACL_ASSERT_NEXT(a_second_hits, load_out && (state_q == S_SECOND), out_q.was_hit && out_q.last, "second modify access did not hit")
  `SACL_ASSERT_NEXT(a_one_count, load_out, (hit_q + miss_q) == ($past(hit_q) + $past(miss_q) + 32'd1), "access not counted exactly once")

endmodule
